// ===== rtl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg: shared definitions of the delta timer queue
// Sizes, request and status codes used by the queue and its checker.
// ----------------------------------------------------------------------------
package dtq_pkg;

   localparam int NUM_ENTRIES = 32;
   localparam int DELAY_BITS  = 32;

   localparam int ENTRY_BITS  = $clog2(NUM_ENTRIES);
   localparam int COUNT_BITS  = $clog2(NUM_ENTRIES + 1);

   // Fixed widths of the item fields on the ports
   localparam int ID_FIELD_BITS    = 5;
   localparam int DELAY_FIELD_BITS = 32;
   localparam int REQ_DATA_BITS    = 40;
   localparam int RSP_DATA_BITS    = 72;

   typedef logic [1:0] req_code_type;
   localparam req_code_type REQ_ADD    = 2'd0;
   localparam req_code_type REQ_REMOVE = 2'd1;
   localparam req_code_type REQ_PEEK   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STS_OK      = 2'd0;
   localparam status_type STS_EMPTY   = 2'd1;
   localparam status_type STS_PRESENT = 2'd2;
   localparam status_type STS_ABSENT  = 2'd3;

endpackage

// ===== rtl/delta_timer_queue_unit.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_unit: differential timer queue
// Keeps numbered entries in a doubly linked chain ordered by absolute delay;
// each entry stores only its delta to the entry in front of it. Add walks
// the chain with one shared add/subtract unit, remove merges the delta of
// the unlinked entry into its successor, peek reports the head.
//
//   channel | dir | tuser            | tdata (lowest bit first)
//   --------+-----+------------------+-------------------------------------
//   req     | in  | [1:0] req_type   | [4:0] entry_id, [36:5] delay, 0 pad
//   rsp     | out | [1:0] status     | [0] first_valid, [5:1] first_id,
//           |     |                  | [37:6] first_delta,
//           |     |                  | [69:38] removed_delta, 0 pad
//
// The add walk visits one chain entry per cycle through the single read
// port of the link and delta memories.
// req_tready is high only while the sequencer is idle; one item at a time.
// A finished item waits in the rsp output register; the next item is taken
// meanwhile and stalls only at its own final step.
// Reset clears the membership flags, head, tail and count at once; the
// delta and link memories need no clearing pass.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // entry_id[4:0], delay[36:5], zero pad
   input  logic [1:0]  req_tuser,   // req_type[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // first_valid[0], first_id[5:1],
                                    // first_delta[37:6], removed_delta[69:38]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int EB = dtq_pkg::ENTRY_BITS;
   localparam int CB = dtq_pkg::COUNT_BITS;
   localparam int DB = dtq_pkg::DELAY_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_LINK_A,
      S_LINK_B,
      S_RM_GET,
      S_RM_UPD,
      S_FIN_RD,
      S_FIN
   } state_type;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type                 state_ff,   state_in;
   dtq_pkg::req_code_type     typ_ff,     typ_in;
   logic [EB-1:0]             id_ff,      id_in;
   logic                      range_ff,   range_in;
   logic [DB-1:0]             rest_ff,    rest_in;
   logic [EB-1:0]             cur_ff,     cur_in;
   logic [CB-1:0]             k_ff,       k_in;
   logic                      found_ff,   found_in;
   logic [EB-1:0]             head_ff,    head_in;
   logic [EB-1:0]             tail_ff,    tail_in;
   logic [CB-1:0]             count_ff,   count_in;
   logic [dtq_pkg::NUM_ENTRIES-1:0] flags_ff, flags_in;
   dtq_pkg::status_type       status_ff,  status_in;
   logic [DB-1:0]             removed_ff, removed_in;
   logic [EB-1:0]             nx_ff,      nx_in;
   logic [EB-1:0]             pv_ff,      pv_in;
   logic                      ishead_ff,  ishead_in;
   logic                      istail_ff,  istail_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [71:0]               rsp_data_ff,  rsp_data_in;
   dtq_pkg::status_type       rsp_user_ff,  rsp_user_in;

   // ---------------------------------------------------------------------
   // Delta, next and prev memories: one write port each, one shared read
   // address, registered read data
   // ---------------------------------------------------------------------
   logic [DB-1:0] delta_mem [dtq_pkg::NUM_ENTRIES];
   logic [EB-1:0] next_mem  [dtq_pkg::NUM_ENTRIES];
   logic [EB-1:0] prev_mem  [dtq_pkg::NUM_ENTRIES];

   logic          rd_en;
   logic [EB-1:0] rd_addr;
   logic [DB-1:0] rd_delta_ff;
   logic [EB-1:0] rd_next_ff;
   logic [EB-1:0] rd_prev_ff;

   logic          dwr_en, nwr_en, pwr_en;
   logic [EB-1:0] dwr_addr, nwr_addr, pwr_addr;
   logic [DB-1:0] dwr_data;
   logic [EB-1:0] nwr_data, pwr_data;

   always_ff @(posedge clock) begin
      if (dwr_en) begin
         delta_mem[dwr_addr] <= dwr_data;
      end
      if (nwr_en) begin
         next_mem[nwr_addr] <= nwr_data;
      end
      if (pwr_en) begin
         prev_mem[pwr_addr] <= pwr_data;
      end
      if (rd_en) begin
         rd_delta_ff <= delta_mem[rd_addr];
         rd_next_ff  <= next_mem[rd_addr];
         rd_prev_ff  <= prev_mem[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Shared add/subtract unit: walk compare, successor reduce, merge on
   // remove. With subtract, carry high means a >= b.
   // ---------------------------------------------------------------------
   logic [DB-1:0] alu_a, alu_b, alu_sum;
   logic          alu_sub, alu_carry;

   always_comb begin
      alu_a   = rest_ff;
      alu_b   = rd_delta_ff;
      alu_sub = 1'b1;
      unique case (state_ff)
         S_LINK_A: begin
            alu_a = rd_delta_ff;
            alu_b = rest_ff;
         end
         S_RM_UPD: begin
            alu_a   = rd_delta_ff;
            alu_b   = removed_ff;
            alu_sub = 1'b0;
         end
         default: begin
         end
      endcase
   end

   assign {alu_carry, alu_sum} = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                               + {{DB{1'b0}}, alu_sub};

   // ---------------------------------------------------------------------
   // Request decode helpers
   // ---------------------------------------------------------------------
   logic req_fire;
   logic out_free;
   logic member;
   logic [dtq_pkg::ID_FIELD_BITS-1:0]    req_id;
   logic [dtq_pkg::DELAY_FIELD_BITS-1:0] req_delay;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign member     = flags_ff[id_ff];
   assign req_id     = req_tdata[dtq_pkg::ID_FIELD_BITS-1:0];
   assign req_delay  = req_tdata[dtq_pkg::ID_FIELD_BITS +: dtq_pkg::DELAY_FIELD_BITS];

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      typ_in       = typ_ff;
      id_in        = id_ff;
      range_in     = range_ff;
      rest_in      = rest_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      found_in     = found_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      flags_in     = flags_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      nx_in        = nx_ff;
      pv_in        = pv_ff;
      ishead_in    = ishead_ff;
      istail_in    = istail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      rd_en    = 1'b0;
      rd_addr  = head_ff;
      dwr_en   = 1'b0;
      dwr_addr = id_ff;
      dwr_data = rest_ff;
      nwr_en   = 1'b0;
      nwr_addr = id_ff;
      nwr_data = cur_ff;
      pwr_en   = 1'b0;
      pwr_addr = id_ff;
      pwr_data = rd_prev_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               typ_in     = req_tuser;
               id_in      = EB'(req_id);
               range_in   = (32'(req_id) < 32'(dtq_pkg::NUM_ENTRIES));
               rest_in    = DB'(req_delay);
               removed_in = '0;
               status_in  = dtq_pkg::STS_OK;
               state_in   = S_DECODE;
            end
         end

         S_DECODE: begin
            state_in = S_FIN_RD;
            unique case (typ_ff)
               dtq_pkg::REQ_ADD: begin
                  if (!range_ff) begin
                     status_in = dtq_pkg::STS_ABSENT;
                  end else if (member) begin
                     status_in = dtq_pkg::STS_PRESENT;
                  end else if (32'(count_ff) >= 32'(dtq_pkg::NUM_ENTRIES)) begin
                     status_in = dtq_pkg::STS_ABSENT;
                  end else if (count_ff == '0) begin
                     found_in = 1'b0;
                     state_in = S_LINK_B;
                  end else begin
                     // start the walk at the head
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     cur_in   = head_ff;
                     k_in     = '0;
                     state_in = S_WALK;
                  end
               end
               dtq_pkg::REQ_REMOVE: begin
                  if (!range_ff || !member) begin
                     status_in = dtq_pkg::STS_ABSENT;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = id_ff;
                     state_in = S_RM_GET;
                  end
               end
               default: begin
                  // peek, and the unused code handled the same way
                  status_in = (count_ff == '0) ? dtq_pkg::STS_EMPTY : dtq_pkg::STS_OK;
               end
            endcase
         end

         S_WALK: begin
            if (!alu_carry) begin
               // remaining delay strictly below this delta: insert in front
               found_in = 1'b1;
               state_in = S_LINK_A;
            end else begin
               rest_in = alu_sum;
               if (k_ff == count_ff - CB'(1)) begin
                  found_in = 1'b0;
                  state_in = S_LINK_A;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rd_next_ff;
                  cur_in  = rd_next_ff;
                  k_in    = k_ff + CB'(1);
               end
            end
         end

         S_LINK_A: begin
            if (found_ff) begin
               // reduce the successor, point the new entry at it
               dwr_en   = 1'b1;
               dwr_addr = cur_ff;
               dwr_data = alu_sum;
               nwr_en   = 1'b1;
               nwr_addr = id_ff;
               nwr_data = cur_ff;
               pwr_en   = (cur_ff != head_ff);
               pwr_addr = id_ff;
               pwr_data = rd_prev_ff;
            end else begin
               // append behind the tail
               nwr_en   = 1'b1;
               nwr_addr = tail_ff;
               nwr_data = id_ff;
               pwr_en   = 1'b1;
               pwr_addr = id_ff;
               pwr_data = tail_ff;
            end
            state_in = S_LINK_B;
         end

         S_LINK_B: begin
            dwr_en   = 1'b1;
            dwr_addr = id_ff;
            dwr_data = rest_ff;
            if (count_ff == '0) begin
               head_in = id_ff;
               tail_in = id_ff;
            end else if (found_ff) begin
               if (cur_ff == head_ff) begin
                  head_in = id_ff;
               end else begin
                  nwr_en   = 1'b1;
                  nwr_addr = rd_prev_ff;
                  nwr_data = id_ff;
               end
               pwr_en   = 1'b1;
               pwr_addr = cur_ff;
               pwr_data = id_ff;
            end else begin
               tail_in = id_ff;
            end
            flags_in[id_ff] = 1'b1;
            count_in        = count_ff + CB'(1);
            state_in        = S_FIN_RD;
         end

         S_RM_GET: begin
            removed_in = rd_delta_ff;
            nx_in      = rd_next_ff;
            pv_in      = rd_prev_ff;
            ishead_in  = (id_ff == head_ff);
            istail_in  = (id_ff == tail_ff);
            if (id_ff != tail_ff) begin
               rd_en   = 1'b1;
               rd_addr = rd_next_ff;
            end
            state_in = S_RM_UPD;
         end

         S_RM_UPD: begin
            if (!istail_ff) begin
               // merge the removed delta into the successor
               dwr_en   = 1'b1;
               dwr_addr = nx_ff;
               dwr_data = alu_sum;
            end
            if (ishead_ff && istail_ff) begin
               head_in = '0;
               tail_in = '0;
            end else if (ishead_ff) begin
               head_in = nx_ff;
            end else if (istail_ff) begin
               tail_in = pv_ff;
            end else begin
               nwr_en   = 1'b1;
               nwr_addr = pv_ff;
               nwr_data = nx_ff;
               pwr_en   = 1'b1;
               pwr_addr = nx_ff;
               pwr_data = pv_ff;
            end
            flags_in[id_ff] = 1'b0;
            count_in        = count_ff - CB'(1);
            state_in        = S_FIN_RD;
         end

         S_FIN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = head_ff;
            state_in = S_FIN;
         end

         S_FIN: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               rsp_data_in  = '0;
               if (count_ff != '0) begin
                  rsp_data_in[0]    = 1'b1;
                  rsp_data_in[5:1]  = dtq_pkg::ID_FIELD_BITS'(head_ff);
                  rsp_data_in[37:6] = dtq_pkg::DELAY_FIELD_BITS'(rd_delta_ff);
               end
               rsp_data_in[69:38] = dtq_pkg::DELAY_FIELD_BITS'(removed_ff);
               state_in           = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      typ_ff      <= typ_in;
      id_ff       <= id_in;
      range_ff    <= range_in;
      rest_ff     <= rest_in;
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      nx_ff       <= nx_in;
      pv_ff       <= pv_in;
      ishead_ff   <= ishead_in;
      istail_ff   <= istail_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/dtq_checker.sv =====
// ----------------------------------------------------------------------------
// dtq_checker: port-level checks of the delta timer queue
// Watches both channels of the top level and flags protocol or result slips.
// ----------------------------------------------------------------------------
module dtq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // no result item right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one item at a time: no new item right after an accepted one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after an accepted item");

   // empty queue: head fields are zero, and an empty status means empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (!rsp_tdata[0] || rsp_tuser == dtq_pkg::STS_EMPTY)
         |-> rsp_tdata[37:0] == 38'd0)
      else $error("head fields set for an empty queue");

   // a refused request reports no removed delta
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != dtq_pkg::STS_OK |-> rsp_tdata[69:38] == 32'd0)
      else $error("removed delta on a refused request");

endmodule

bind delta_timer_queue_unit dtq_checker u_dtq_checker (.*);

// ===== tb/delta_timer_queue_unit_tb.sv =====
// ----------------------------------------------------------------------------
// delta_timer_queue_unit_tb: self-checking bench of the delta timer queue
// Drives add, remove and peek items into the request channel, predicts every
// response with a private copy of the delta chain, and compares each
// response field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module delta_timer_queue_unit_tb;

   // Request type 3 is decoded like a peek
   localparam dtq_pkg::req_code_type REQ_PEEK_ALT = 2'd3;

   // Generous bound: ~505 items at worst-case walk plus both-side gaps stay
   // well under this limit
   localparam int CYCLE_LIMIT = 250000;
   localparam int RANDOM_ITEMS = 480;

   typedef logic [dtq_pkg::DELAY_FIELD_BITS-1:0] field_word_type;

   // One expected response, unpacked
   typedef struct {
      dtq_pkg::status_type                  status;
      logic                                 first_valid;
      logic [dtq_pkg::ID_FIELD_BITS-1:0]    first_id;
      logic [dtq_pkg::DELAY_FIELD_BITS-1:0] first_delta;
      logic [dtq_pkg::DELAY_FIELD_BITS-1:0] removed_delta;
   } queue_view_type;

   // -------------------------------------------------------------------------
   // Scoreboard: shadow delta chain plus the queue of outstanding responses
   // -------------------------------------------------------------------------
   class timer_queue_board;
      logic [dtq_pkg::DELAY_BITS-1:0] delta_mem [dtq_pkg::NUM_ENTRIES];
      logic [dtq_pkg::ENTRY_BITS-1:0] next_mem  [dtq_pkg::NUM_ENTRIES];
      logic [dtq_pkg::ENTRY_BITS-1:0] prev_mem  [dtq_pkg::NUM_ENTRIES];
      bit                             member    [dtq_pkg::NUM_ENTRIES];
      logic [dtq_pkg::ENTRY_BITS-1:0] head;
      logic [dtq_pkg::ENTRY_BITS-1:0] tail;
      int unsigned                    count;
      queue_view_type                 pending_views [$];
      int unsigned                    errors;

      function new();
         foreach (member[i]) begin
            member[i]    = 1'b0;
            delta_mem[i] = '0;
            next_mem[i]  = '0;
            prev_mem[i]  = '0;
         end
         head   = '0;
         tail   = '0;
         count  = 0;
         errors = 0;
      endfunction

      // Apply one accepted request to the shadow chain, queue its response
      function void note_request(dtq_pkg::req_code_type kind,
                                 logic [dtq_pkg::ID_FIELD_BITS-1:0] id,
                                 logic [dtq_pkg::DELAY_FIELD_BITS-1:0] dly);
         queue_view_type                 v;
         logic [dtq_pkg::DELAY_BITS-1:0] rest;
         logic [dtq_pkg::ENTRY_BITS-1:0] cur;
         logic [dtq_pkg::ENTRY_BITS-1:0] nx;
         logic [dtq_pkg::ENTRY_BITS-1:0] pv;
         bit                             found;
         int unsigned                    k;

         v.removed_delta = '0;
         case (kind)
            dtq_pkg::REQ_ADD: begin
               if (id >= dtq_pkg::NUM_ENTRIES) begin
                  v.status = dtq_pkg::STS_ABSENT;
               end else if (member[id]) begin
                  v.status = dtq_pkg::STS_PRESENT;
               end else if (count >= dtq_pkg::NUM_ENTRIES) begin
                  v.status = dtq_pkg::STS_ABSENT;
               end else begin
                  // walk: subtract deltas until the remainder falls below one
                  rest  = dly[dtq_pkg::DELAY_BITS-1:0];
                  cur   = head;
                  found = 1'b0;
                  for (k = 0; k < count; k++) begin
                     if (rest < delta_mem[cur]) begin
                        delta_mem[cur] = delta_mem[cur] - rest;
                        found = 1'b1;
                        break;
                     end
                     rest = rest - delta_mem[cur];
                     cur  = next_mem[cur];
                  end
                  delta_mem[id] = rest;
                  if (count == 0) begin
                     head = id;
                     tail = id;
                  end else if (found) begin
                     next_mem[id] = cur;
                     if (cur == head) begin
                        head = id;
                     end else begin
                        prev_mem[id]           = prev_mem[cur];
                        next_mem[prev_mem[cur]] = id;
                     end
                     prev_mem[cur] = id;
                  end else begin
                     next_mem[tail] = id;
                     prev_mem[id]   = tail;
                     tail           = id;
                  end
                  member[id] = 1'b1;
                  count++;
                  v.status = dtq_pkg::STS_OK;
               end
            end
            dtq_pkg::REQ_REMOVE: begin
               if (id >= dtq_pkg::NUM_ENTRIES || !member[id]) begin
                  v.status = dtq_pkg::STS_ABSENT;
               end else begin
                  nx = next_mem[id];
                  pv = prev_mem[id];
                  v.removed_delta = delta_mem[id];
                  // merge the delta into the successor; a tail delta is dropped
                  if (id != tail) delta_mem[nx] = delta_mem[nx] + delta_mem[id];
                  if (id == head && id == tail) begin
                     head = '0;
                     tail = '0;
                  end else if (id == head) begin
                     head = nx;
                  end else if (id == tail) begin
                     tail = pv;
                  end else begin
                     next_mem[pv] = nx;
                     prev_mem[nx] = pv;
                  end
                  member[id] = 1'b0;
                  count--;
                  v.status = dtq_pkg::STS_OK;
               end
            end
            default: begin
               v.status = (count == 0) ? dtq_pkg::STS_EMPTY : dtq_pkg::STS_OK;
            end
         endcase

         v.first_valid = (count != 0);
         v.first_id    = (count != 0) ? head : '0;
         v.first_delta = (count != 0) ? delta_mem[head] : '0;
         pending_views.push_back(v);
      endfunction

      function void check_field(string label, field_word_type want, field_word_type got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, label, want, got);
         end
      endfunction

      // Compare one accepted response against the oldest expectation
      function void check_result(logic [1:0] sts,
                                 logic [dtq_pkg::RSP_DATA_BITS-1:0] data);
         queue_view_type want;
         queue_view_type got;

         got.status        = sts;
         got.first_valid   = data[0];
         got.first_id      = data[5:1];
         got.first_delta   = data[37:6];
         got.removed_delta = data[69:38];
         if (pending_views.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual status %0d data %0h",
                     $time, sts, data);
            return;
         end
         want = pending_views.pop_front();
         check_field("status", field_word_type'(want.status),
                     field_word_type'(got.status));
         check_field("first_valid", field_word_type'(want.first_valid),
                     field_word_type'(got.first_valid));
         check_field("first_id", field_word_type'(want.first_id),
                     field_word_type'(got.first_id));
         check_field("first_delta",   want.first_delta,   got.first_delta);
         check_field("removed_delta", want.removed_delta, got.removed_delta);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block under test
   // -------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // entry_id[4:0], delay[36:5], zero pad
   logic [1:0]  req_tuser = '0;   // req_type[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // first_valid[0], first_id[5:1],
                                  // first_delta[37:6], removed_delta[69:38]
   logic [1:0]  rsp_tuser;        // status[1:0]

   timer_queue_board board;
   int unsigned      cycle_count = 0;
   logic [31:0]      in_queue = '0;   // stimulus-side view of which ids are members
   bit               send_burst = 1'b0;
   bit               take_burst = 1'b0;
   int unsigned      sent = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   delta_timer_queue_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // -------------------------------------------------------------------------
   // Monitors: sample both handshakes at the edge, before the block updates
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         board.note_request(req_tuser, req_tdata[4:0], req_tdata[36:5]);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // Watchdog: end the run if the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request driver
   // -------------------------------------------------------------------------
   // Present one item after a random gap and hold it until accepted. Valid
   // is lowered only when a gap follows, so it never toggles within a step.
   task automatic send_item(input dtq_pkg::req_code_type kind, input logic [4:0] id,
                            input logic [31:0] dly);
      int gap;
      if (sent % 37 == 0) send_burst = ($urandom_range(0, 2) == 0);
      gap = send_burst ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, dly, id};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      // track membership the way the block will see it
      if (kind == dtq_pkg::REQ_ADD)    in_queue[id] = 1'b1;
      if (kind == dtq_pkg::REQ_REMOVE) in_queue[id] = 1'b0;
      sent++;
   endtask

   // Pick a random id whose bit is set in mask; any id if none is
   function automatic logic [4:0] pick_id(input logic [31:0] mask);
      int start;
      int i;
      start = $urandom_range(0, 31);
      for (i = 0; i < 32; i++) begin
         if (mask[(start + i) % 32]) return 5'((start + i) % 32);
      end
      return 5'($urandom_range(0, 31));
   endfunction

   // Mix of zero, all-ones, small (to force equal delays) and full-range delays
   function automatic logic [31:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 15);
         3:       return $urandom_range(0, 1000);
         default: return $urandom();
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Response sink: stall at random, with stretches of constant readiness
   // -------------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 29 == 0) take_burst = ($urandom_range(0, 2) == 0);
         stall = take_burst ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_sequence
      int                    n;
      int                    roll;
      bit                    filling;
      dtq_pkg::req_code_type kind;
      logic [4:0]            id;

      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty peek, absent remove, extremes, equal delays, every
      // unlink position, head insertion and the peek alias
      send_item(dtq_pkg::REQ_PEEK,   5'd0,  32'd0);
      send_item(dtq_pkg::REQ_REMOVE, 5'd5,  32'd0);
      send_item(dtq_pkg::REQ_ADD,    5'd0,  32'd0);
      send_item(dtq_pkg::REQ_ADD,    5'd31, 32'hFFFF_FFFF);
      send_item(dtq_pkg::REQ_ADD,    5'd0,  32'd77);          // already present
      send_item(dtq_pkg::REQ_ADD,    5'd7,  32'd0);           // equal delay goes behind
      send_item(dtq_pkg::REQ_ADD,    5'd12, 32'd100);
      send_item(dtq_pkg::REQ_ADD,    5'd3,  32'd100);
      send_item(dtq_pkg::REQ_PEEK,   5'd9,  32'd0);
      send_item(REQ_PEEK_ALT,        5'd31, 32'hFFFF_FFFF);
      send_item(dtq_pkg::REQ_REMOVE, 5'd0,  32'd0);           // head with successor
      send_item(dtq_pkg::REQ_REMOVE, 5'd3,  32'd0);           // middle of chain
      send_item(dtq_pkg::REQ_REMOVE, 5'd31, 32'd0);           // tail
      send_item(dtq_pkg::REQ_REMOVE, 5'd31, 32'd0);           // now absent
      send_item(dtq_pkg::REQ_ADD,    5'd20, 32'd0);
      send_item(dtq_pkg::REQ_ADD,    5'd9,  32'd50);
      send_item(dtq_pkg::REQ_REMOVE, 5'd7,  32'd0);
      send_item(dtq_pkg::REQ_REMOVE, 5'd20, 32'd0);
      send_item(dtq_pkg::REQ_REMOVE, 5'd9,  32'd0);
      send_item(dtq_pkg::REQ_REMOVE, 5'd12, 32'd0);           // last member
      send_item(dtq_pkg::REQ_PEEK,   5'd0,  32'd0);
      send_item(dtq_pkg::REQ_ADD,    5'd1,  32'd1000);
      send_item(dtq_pkg::REQ_ADD,    5'd2,  32'd10);          // insert in front of head
      send_item(dtq_pkg::REQ_REMOVE, 5'd1,  32'd0);
      send_item(dtq_pkg::REQ_REMOVE, 5'd2,  32'd0);

      // Random: alternate fill and drain phases so the chain grows deep and
      // empties again; a small share are duplicate adds and absent removes
      filling = 1'b1;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) filling = !filling || (n == 0);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            kind = dtq_pkg::REQ_PEEK;
            id   = 5'($urandom_range(0, 31));
         end else if (roll < 11) begin
            kind = REQ_PEEK_ALT;
            id   = 5'($urandom_range(0, 31));
         end else if (roll < 14) begin
            kind = dtq_pkg::REQ_ADD;
            id   = pick_id(in_queue);
         end else if (roll < 17) begin
            kind = dtq_pkg::REQ_REMOVE;
            id   = pick_id(~in_queue);
         end else if (roll < (filling ? 75 : 40)) begin
            kind = dtq_pkg::REQ_ADD;
            id   = pick_id(~in_queue);
         end else begin
            kind = dtq_pkg::REQ_REMOVE;
            id   = pick_id(in_queue);
         end
         send_item(kind, id, pick_delay());
      end
      req_tvalid <= 1'b0;

      // Drain, then leave room for any stray response
      while (board.pending_views.size() != 0) @(posedge clock);
      repeat (dtq_pkg::NUM_ENTRIES + 10) @(posedge clock);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
